FILE: rtl/core/atfb_pkg.sv
// shared types and constants for the transmit-request frame builder
// no dependencies
`default_nettype none

package atfb_pkg;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PAYLOAD,
    CMD_ERROR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] frame_id;
    logic [7:0] payload_len;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       add_checksum;
  } cmd_t;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgDestAddress = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxFrameLength = 2'd1;

  localparam logic [7:0] StartDelim = 8'h7E;
  localparam logic [7:0] ApiTxRequest = 8'h10;
  localparam logic [7:0] BcastHi = 8'hFF;
  localparam logic [7:0] BcastLo = 8'hFE;
  localparam logic [7:0] ZeroByte = 8'h00;
  localparam logic [7:0] CkBase = 8'hFF;
  localparam logic [8:0] FixedDataLen = 9'd14;
  localparam logic [8:0] FrameOverhead = 9'd18;
  localparam logic [7:0] MaxFrameReset = 8'd255;

  localparam logic [4:0] StepDelim = 5'd0;
  localparam logic [4:0] StepLenHi = 5'd1;
  localparam logic [4:0] StepLenLo = 5'd2;
  localparam logic [4:0] StepType = 5'd3;
  localparam logic [4:0] StepId = 5'd4;
  localparam logic [4:0] StepAddr0 = 5'd5;
  localparam logic [4:0] StepAddr7 = 5'd12;
  localparam logic [4:0] StepBcHi = 5'd13;
  localparam logic [4:0] StepBcLo = 5'd14;
  localparam logic [4:0] StepRadius = 5'd15;
  localparam logic [4:0] StepOptions = 5'd16;
  localparam logic [4:0] HeaderLen = 5'd17;

endpackage

`default_nettype wire

FILE: rtl/core/atfb_if.sv
// input and output channel interfaces of the frame builder
// no dependencies
`default_nettype none

interface atfb_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_frame;
  logic [7:0] frame_id;
  logic [7:0] payload_len;
  logic [7:0] payload_byte;

  modport source (output valid, start_of_frame, frame_id, payload_len, payload_byte,
                  input ready);
  modport sink (input valid, start_of_frame, frame_id, payload_len, payload_byte,
                output ready);
endinterface

interface atfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       too_long;

  modport source (output valid, out_byte, last_byte, too_long, input ready);
  modport sink (input valid, out_byte, last_byte, too_long, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/atfb_queue.sv
// command queue between front and back of the frame builder
// depends on atfb_pkg
`default_nettype none

module atfb_queue import atfb_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/atfb_front.sv
// front end: accepts input transactions, tracks frame state, issues commands
// depends on atfb_pkg and atfb_if
`default_nettype none

module atfb_front import atfb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  atfb_in_if.sink         in_i,
  input  wire logic [7:0] max_frame_length_i,
  output logic            push_o,
  output cmd_t            cmd_o,
  input  wire logic       full_i
);

  logic [7:0] remaining_q, remaining_d;
  logic       dropping_q, dropping_d;
  logic       accept;
  logic [8:0] total_len;
  logic       too_long;
  logic [7:0] len_m1;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign total_len  = FrameOverhead + {1'b0, in_i.payload_len};
  assign too_long   = total_len > {1'b0, max_frame_length_i};
  assign len_m1     = in_i.payload_len - 8'd1;

  always_comb begin
    remaining_d        = remaining_q;
    dropping_d         = dropping_q;
    push_o             = 1'b0;
    cmd_o.kind         = CMD_PAYLOAD;
    cmd_o.frame_id     = in_i.frame_id;
    cmd_o.payload_len  = in_i.payload_len;
    cmd_o.payload_byte = in_i.payload_byte;
    cmd_o.has_payload  = (in_i.payload_len != '0);
    cmd_o.add_checksum = (in_i.payload_len <= 8'd1);
    if (accept) begin
      if (in_i.start_of_frame) begin
        remaining_d = (in_i.payload_len == '0) ? '0 : len_m1;
        push_o      = 1'b1;
        if (too_long) begin
          cmd_o.kind = CMD_ERROR;
          dropping_d = (in_i.payload_len > 8'd1);
        end else begin
          cmd_o.kind = CMD_START;
          dropping_d = 1'b0;
        end
      end else if (remaining_q != '0) begin
        remaining_d = remaining_q - 8'd1;
        if (dropping_q) begin
          if (remaining_q == 8'd1) begin
            dropping_d = 1'b0;
          end
        end else begin
          push_o             = 1'b1;
          cmd_o.kind         = CMD_PAYLOAD;
          cmd_o.has_payload  = 1'b1;
          cmd_o.add_checksum = (remaining_q == 8'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      dropping_q  <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      dropping_q  <= dropping_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/atfb_back.sv
// back end: expands commands into frame bytes and keeps the checksum
// depends on atfb_pkg and atfb_if
`default_nettype none

module atfb_back import atfb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  input  wire logic [63:0] dest_address_i,
  atfb_out_if.source       out_o
);

  logic [4:0] step_q, step_d;
  logic [7:0] sum_q, sum_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       err_q, err_d;

  logic       advance, fire, is_err, is_ck, last_step, sum_en;
  logic [4:0] n_res;
  logic [2:0] addr_idx;
  logic [8:0] data_len;
  logic [7:0] hdr_byte, cur_byte, ck_byte;

  assign out_o.valid     = valid_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.last_byte = last_q;
  assign out_o.too_long  = err_q;

  assign advance  = !valid_q || out_o.ready;
  assign fire     = advance && !empty_i;
  assign is_err   = (cmd_i.kind == CMD_ERROR);
  assign data_len = FixedDataLen + {1'b0, cmd_i.payload_len};
  assign addr_idx = 3'(step_q - StepAddr0);
  assign ck_byte  = CkBase - sum_q;

  always_comb begin
    unique case (cmd_i.kind)
      CMD_START:   n_res = HeaderLen + 5'(cmd_i.has_payload) + 5'(cmd_i.add_checksum);
      CMD_PAYLOAD: n_res = 5'd1 + 5'(cmd_i.add_checksum);
      default:     n_res = 5'd1;
    endcase
  end

  assign last_step = (step_q == n_res - 5'd1);
  assign is_ck     = !is_err && cmd_i.add_checksum && last_step;
  assign sum_en    = !is_ck && ((cmd_i.kind == CMD_PAYLOAD) ||
                                ((cmd_i.kind == CMD_START) && (step_q >= StepType)));

  always_comb begin
    unique case (step_q) inside
      StepDelim:              hdr_byte = StartDelim;
      StepLenHi:              hdr_byte = {7'd0, data_len[8]};
      StepLenLo:              hdr_byte = data_len[7:0];
      StepType:               hdr_byte = ApiTxRequest;
      StepId:                 hdr_byte = cmd_i.frame_id;
      [StepAddr0:StepAddr7]:  hdr_byte = dest_address_i[{~addr_idx, 3'b000} +: 8];
      StepBcHi:               hdr_byte = BcastHi;
      StepBcLo:               hdr_byte = BcastLo;
      StepRadius, StepOptions: hdr_byte = ZeroByte;
      default:                hdr_byte = cmd_i.payload_byte;
    endcase
  end

  always_comb begin
    if (is_err) begin
      cur_byte = ZeroByte;
    end else if (is_ck) begin
      cur_byte = ck_byte;
    end else if (cmd_i.kind == CMD_START) begin
      cur_byte = hdr_byte;
    end else begin
      cur_byte = cmd_i.payload_byte;
    end
  end

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    err_d   = err_q;
    step_d  = step_q;
    sum_d   = sum_q;
    pop_o   = 1'b0;
    if (fire) begin
      valid_d = 1'b1;
      byte_d  = cur_byte;
      last_d  = is_ck || is_err;
      err_d   = is_err;
      if (last_step) begin
        step_d = '0;
        pop_o  = 1'b1;
      end else begin
        step_d = step_q + 5'd1;
      end
      if ((cmd_i.kind == CMD_START) && (step_q == StepDelim)) begin
        sum_d = '0;
      end else if (sum_en) begin
        sum_d = sum_q + cur_byte;
      end
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
      sum_q   <= '0;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/api_transmit_frame_builder.sv
// top level of the transmit-request frame builder: config registers, front, queue, back
// depends on atfb_pkg, atfb_if, atfb_queue, atfb_front, atfb_back
//
//   channel   direction  transaction
//   in_i      sink       start_of_frame, frame_id, payload_len, payload_byte
//   out_o     source     out_byte, last_byte, too_long
//   cfg_*     write      cfg_idx_i selects register, cfg_data_i carries value
//
// a start transaction emits 18 or 19 bytes, one when refused; a payload one emits one or two, none when idle or dropped
// the back end emits one byte per cycle while the output is ready; its rate sets throughput
// the front keeps accepting until the QueueDepth-entry command queue fills
// reset clears frame state, queue and output valid; no clearing pass
// input and output stall independently through the queue and the output register
`default_nettype none

module api_transmit_frame_builder import atfb_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  atfb_in_if.sink                 in_i,
  atfb_out_if.source              out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]        cfg_data_i
);

  logic [63:0] dest_q;
  logic [7:0]  max_len_q;
  logic        push, full, pop, empty;
  cmd_t        push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q    <= '0;
      max_len_q <= MaxFrameReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDestAddress) begin
        dest_q <= cfg_data_i;
      end else if (cfg_idx_i == CfgMaxFrameLength) begin
        max_len_q <= cfg_data_i[7:0];
      end
    end
  end

  atfb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_i               (in_i),
    .max_frame_length_i (max_len_q),
    .push_o             (push),
    .cmd_o              (push_cmd),
    .full_i             (full)
  );

  atfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .empty_o     (empty)
  );

  atfb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .empty_i        (empty),
    .pop_o          (pop),
    .dest_address_i (dest_q),
    .out_o          (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/atfb_checker.sv
// port-level checks on the frame builder output channel, bound to the top level
// depends on api_transmit_frame_builder
`default_nettype none

module atfb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       last_byte_i,
  input wire logic       too_long_i
);

  // stalled output holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(last_byte_i) && $stable(too_long_i))
    else $error("output changed while stalled");

  // error result is a lone zero closing byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && too_long_i |-> last_byte_i && (out_byte_i == 8'h00))
    else $error("malformed error result");

  // nothing shown right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid out of reset");

endmodule

bind api_transmit_frame_builder atfb_checker u_atfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .last_byte_i (out_o.last_byte),
  .too_long_i  (out_o.too_long)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for api_transmit_frame_builder: predicts the frame bytes of every
// input transaction and checks the output stream in order; depends on atfb_pkg, atfb_if, rtl top

module tb_top;
  import atfb_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles = 400;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare3 = 2'd3;
  localparam logic [7:0] Delim = 8'h7E;
  localparam logic [7:0] TxRequestType = 8'h10;
  localparam logic [7:0] BroadcastHi = 8'hFF;
  localparam logic [7:0] BroadcastLo = 8'hFE;
  localparam logic [7:0] RadiusByte = 8'h00;
  localparam logic [7:0] OptionsByte = 8'h00;
  localparam logic [7:0] ChecksumBase = 8'hFF;
  localparam logic [7:0] LimitAtReset = 8'd255;
  localparam int LenOffset = 14;
  localparam int Overhead = 18;

  typedef struct {
    logic       sof;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] pb;
  } tx_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } wire_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [63:0]       cfg_data;

  atfb_in_if  in_if ();
  atfb_out_if out_if ();

  api_transmit_frame_builder uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // frame builder mirror: configuration and per-frame state
  logic [63:0] dest_addr;
  logic [7:0]  frame_limit;
  logic [7:0]  bytes_left;
  logic [7:0]  sum_acc;
  logic        dropping;

  tx_item_t   pending_q[$];
  wire_byte_t wire_bytes_q[$];
  tx_item_t   offer;
  tx_item_t   taken;
  wire_byte_t head;

  int errors;
  int cycle_count;
  int send_gap;
  int stall_left;
  int hold_left;
  bit in_fire;
  bit calm;
  bit hold_kick;

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] rnd8();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void emit(input logic [7:0] b, input logic last, input logic err,
                               input bit summed);
    wire_byte_t w;
    w.data = b;
    w.last = last;
    w.err = err;
    wire_bytes_q.push_back(w);
    if (summed) sum_acc = sum_acc + b;
  endfunction

  function automatic void assemble_bytes(input tx_item_t it);
    logic [15:0] data_len;
    int i;
    data_len = 16'(LenOffset + it.len);
    if (it.sof) begin
      sum_acc = '0;
      if (Overhead + it.len > frame_limit) begin
        emit(8'h00, 1'b1, 1'b1, 1'b0);
        bytes_left = (it.len != 8'd0) ? it.len - 8'd1 : 8'd0;
        dropping = (bytes_left != 8'd0);
        return;
      end
      dropping = 1'b0;
      emit(Delim, 1'b0, 1'b0, 1'b0);
      emit(data_len[15:8], 1'b0, 1'b0, 1'b0);
      emit(data_len[7:0], 1'b0, 1'b0, 1'b0);
      emit(TxRequestType, 1'b0, 1'b0, 1'b1);
      emit(it.id, 1'b0, 1'b0, 1'b1);
      for (i = 7; i >= 0; i--) emit(dest_addr[8*i +: 8], 1'b0, 1'b0, 1'b1);
      emit(BroadcastHi, 1'b0, 1'b0, 1'b1);
      emit(BroadcastLo, 1'b0, 1'b0, 1'b1);
      emit(RadiusByte, 1'b0, 1'b0, 1'b1);
      emit(OptionsByte, 1'b0, 1'b0, 1'b1);
      if (it.len == 8'd0) begin
        bytes_left = 8'd0;
        emit(ChecksumBase - sum_acc, 1'b1, 1'b0, 1'b0);
        return;
      end
      emit(it.pb, 1'b0, 1'b0, 1'b1);
      bytes_left = it.len - 8'd1;
      if (bytes_left == 8'd0) emit(ChecksumBase - sum_acc, 1'b1, 1'b0, 1'b0);
      return;
    end
    // non-start transaction: idle outside a frame, else a payload byte or a dropped one
    if (bytes_left == 8'd0) return;
    bytes_left = bytes_left - 8'd1;
    if (dropping) begin
      if (bytes_left == 8'd0) dropping = 1'b0;
      return;
    end
    emit(it.pb, 1'b0, 1'b0, 1'b1);
    if (bytes_left == 8'd0) emit(ChecksumBase - sum_acc, 1'b1, 1'b0, 1'b0);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("%0t mismatch %s: got %02h want %02h (%0d queued)", $time, what, got, want,
             wire_bytes_q.size());
  endtask

  // monitor: output check, then prediction for the accepted input transaction
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (wire_bytes_q.size() == 0) begin
        report_mismatch("byte with nothing expected", out_if.out_byte, 8'h00);
      end else begin
        head = wire_bytes_q.pop_front();
        if (out_if.out_byte !== head.data) report_mismatch("out_byte", out_if.out_byte, head.data);
        if (out_if.last_byte !== head.last)
          report_mismatch("last_byte", {7'd0, out_if.last_byte}, {7'd0, head.last});
        if (out_if.too_long !== head.err)
          report_mismatch("too_long", {7'd0, out_if.too_long}, {7'd0, head.err});
      end
    end
    in_fire = rst_ni && in_if.valid && in_if.ready;
    if (in_fire) begin
      taken.sof = in_if.start_of_frame;
      taken.id = in_if.frame_id;
      taken.len = in_if.payload_len;
      taken.pb = in_if.payload_byte;
      assemble_bytes(taken);
    end
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!in_if.valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        offer = pending_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.start_of_frame <= offer.sof;
        in_if.frame_id <= offer.id;
        in_if.payload_len <= offer.len;
        in_if.payload_byte <= offer.pb;
        send_gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_kick) begin
      hold_left = HoldCycles;
      hold_kick = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  function automatic void queue_item(input logic sof, input logic [7:0] id,
                                     input logic [7:0] len, input logic [7:0] pb);
    tx_item_t it;
    it.sof = sof;
    it.id = id;
    it.len = len;
    it.pb = pb;
    pending_q.push_back(it);
  endfunction

  // start transaction plus sent-1 payload transactions; returns transactions queued
  function automatic int queue_frame(input int len, input int sent);
    int k;
    logic [7:0] len8;
    len8 = 8'(len);
    queue_item(1'b1, rnd8(), len8, rnd8());
    for (k = 1; k < sent; k++) queue_item(1'b0, rnd8(), rnd8(), rnd8());
    return (sent > 0) ? sent : 1;
  endfunction

  task automatic queue_random_frames(input int budget);
    int counted;
    int pick;
    int len;
    int sent;
    counted = 0;
    while (counted < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) len = $urandom_range(0, 8);
      else if (pick < 97) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 255);
      sent = len;
      // truncated frame, the next start abandons it
      if (len > 1 && $urandom_range(0, 9) == 0) sent = $urandom_range(1, len - 1);
      counted += queue_frame(len, sent);
      if (sent == len && $urandom_range(0, 9) == 0) queue_item(1'b0, rnd8(), rnd8(), rnd8());
    end
  endtask

  // largest frame that fits and the one just above it, if that fit is at most 40; lengths 0 and 1 if none fits
  task automatic queue_boundary();
    int fit_len;
    int unused;
    fit_len = int'(frame_limit) - Overhead;
    if (fit_len < 0) begin
      unused = queue_frame(0, 0);
      unused = queue_frame(1, 1);
    end else if (fit_len <= 40) begin
      unused = queue_frame(fit_len, fit_len);
      unused = queue_frame(fit_len + 1, fit_len + 1);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgDestAddress: dest_addr = val;
      CfgMaxFrameLength: frame_limit = val[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] limit_word(input logic [7:0] lim);
    logic [63:0] v;
    v = {$urandom, $urandom};
    v[7:0] = lim;
    return v;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_if.valid || wire_bytes_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    in_if.valid = 1'b0;
    in_if.start_of_frame = 1'b0;
    in_if.frame_id = 8'h00;
    in_if.payload_len = 8'h00;
    in_if.payload_byte = 8'h00;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgDestAddress;
    cfg_data = 64'd0;
    rst_ni = 1'b0;
    dest_addr = 64'd0;
    frame_limit = LimitAtReset;
    bytes_left = 8'd0;
    sum_acc = 8'd0;
    dropping = 1'b0;
    errors = 0;
    cycle_count = 0;
    send_gap = 0;
    stall_left = 0;
    hold_left = 0;
    in_fire = 1'b0;
    calm = 1'b0;
    hold_kick = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle, zero length, single byte, short frame, restart, refused then abandoned
    queue_item(1'b0, rnd8(), rnd8(), rnd8());
    queue_item(1'b1, 8'h00, 8'd0, rnd8());
    queue_item(1'b1, 8'hFF, 8'd1, 8'hFF);
    queue_item(1'b1, 8'h5A, 8'd3, 8'h00);
    queue_item(1'b0, rnd8(), rnd8(), 8'hAA);
    queue_item(1'b0, rnd8(), rnd8(), 8'h55);
    queue_item(1'b0, rnd8(), rnd8(), rnd8());
    queue_item(1'b1, 8'h01, 8'd6, 8'h80);
    queue_item(1'b0, rnd8(), rnd8(), 8'h7F);
    queue_item(1'b1, 8'h02, 8'd2, 8'h01);
    queue_item(1'b0, rnd8(), rnd8(), 8'hFE);
    queue_item(1'b1, rnd8(), 8'd255, rnd8());
    queue_item(1'b0, rnd8(), rnd8(), rnd8());
    queue_item(1'b0, rnd8(), rnd8(), rnd8());
    queue_item(1'b1, 8'h33, 8'd0, rnd8());
    wait_idle();

    // long receiver hold-off fills the block
    write_reg(CfgDestAddress, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgMaxFrameLength, limit_word(8'd255));
    hold_kick = 1'b1;
    queue_random_frames(90);
    wait_idle();

    write_reg(CfgDestAddress, 64'h0123_4567_89AB_CDEF);
    write_reg(CfgMaxFrameLength, limit_word(8'd18));
    write_reg(CfgIdxSpare2, {$urandom, $urandom});
    write_reg(CfgIdxSpare3, {$urandom, $urandom});
    queue_boundary();
    queue_random_frames(40);
    wait_idle();

    write_reg(CfgDestAddress, 64'd0);
    write_reg(CfgMaxFrameLength, limit_word(8'd0));
    queue_boundary();
    queue_random_frames(40);
    wait_idle();

    write_reg(CfgDestAddress, {$urandom, $urandom});
    write_reg(CfgMaxFrameLength, limit_word(8'($urandom_range(19, 60))));
    calm = 1'b1;
    queue_boundary();
    queue_random_frames(90);
    wait_idle();
    calm = 1'b0;

    write_reg(CfgDestAddress, 64'h8000_0000_0000_0001);
    write_reg(CfgMaxFrameLength, limit_word(8'd255));
    queue_random_frames(120);
    wait_idle();

    write_reg(CfgIdxSpare3, {$urandom, $urandom});
    write_reg(CfgDestAddress, {$urandom, $urandom});
    write_reg(CfgMaxFrameLength, limit_word(rnd8()));
    write_reg(CfgIdxSpare2, {$urandom, $urandom});
    queue_boundary();
    queue_random_frames(80);
    wait_idle();

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
